// File: hw/rtl/sh32_pkg.sv
// Shared types, constants and key schedule / round functions for the Shadow-32 encryptor.
package sh32_pkg;

   localparam int MAX_ROUNDS = 16;
   localparam int KEY_W      = 64;

   typedef struct packed {
      logic [7:0] left_a;
      logic [7:0] right_a;
      logic [7:0] left_b;
      logic [7:0] right_b;
   } req_type;

   typedef struct packed {
      logic [7:0] cipher_left_a;
      logic [7:0] cipher_right_a;
      logic [7:0] cipher_left_b;
      logic [7:0] cipher_right_b;
   } rsp_type;

   // working state of one block between rounds
   typedef struct packed {
      logic [7:0] l0;
      logic [7:0] r0;
      logic [7:0] l1;
      logic [7:0] r1;
   } blk_type;

   typedef struct packed {
      logic [7:0] k0;
      logic [7:0] k1;
      logic [7:0] k2;
      logic [7:0] k3;
   } subkey_type;

   // Key positions count from the MSB: position p lives in vector bit 63-p, i.e. ~p.
   localparam logic [5:0] PERM_TAB [KEY_W] = '{
      6'd56, 6'd57, 6'd58, 6'd59, 6'd16, 6'd17, 6'd18, 6'd19,
      6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27,
      6'd60, 6'd61, 6'd62, 6'd63, 6'd28, 6'd29, 6'd30, 6'd31,
      6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39,
      6'd40, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47,
      6'd48, 6'd49, 6'd50, 6'd51, 6'd52, 6'd53, 6'd54, 6'd55,
      6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,  6'd7,
      6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15
   };

   localparam logic [5:0] SEL_TAB [4][8] = '{
      '{6'd0,  6'd1,  6'd2,  6'd3,  6'd8,  6'd9,  6'd10, 6'd11},
      '{6'd4,  6'd5,  6'd6,  6'd7,  6'd12, 6'd13, 6'd14, 6'd15},
      '{6'd16, 6'd17, 6'd18, 6'd19, 6'd24, 6'd25, 6'd26, 6'd27},
      '{6'd20, 6'd21, 6'd22, 6'd23, 6'd28, 6'd29, 6'd30, 6'd31}
   };

   function automatic logic [7:0] f_round(input logic [7:0] x);
      logic [7:0] r1;
      logic [7:0] r2;
      logic [7:0] r7;
      r1 = {x[6:0], x[7]};
      r2 = {x[5:0], x[7:6]};
      r7 = {x[0], x[7:1]};
      return (r1 & r7) ^ r2;
   endfunction

   // one schedule round: NX update of positions 56..63, then the permutation
   function automatic logic [KEY_W-1:0] key_step(input logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] nx;
      logic [KEY_W-1:0] res;
      nx    = k;
      nx[7] = k[7] & (k[7] ^ k[1]);
      nx[6] = k[6] & (k[6] ^ k[0]);
      nx[5] = k[5] & (k[5] ^ k[7] ^ k[1]);
      nx[4] = k[4] & (k[4] ^ k[6] ^ k[0]);
      nx[3] = k[3] & (k[3] ^ k[5] ^ k[7] ^ k[1]);
      nx[2] = k[2] & (k[2] ^ k[4] ^ k[6] ^ k[0]);
      nx[1] = k[1] & (k[3] ^ k[5] ^ k[7]);
      nx[0] = k[0] & (k[2] ^ k[4] ^ k[6]);
      for (int i = 0; i < KEY_W; i++) begin
         res[~6'(i)] = nx[~PERM_TAB[i]];
      end
      return res;
   endfunction

   function automatic logic [7:0] gather(input logic [KEY_W-1:0] k, input int s);
      logic [7:0] v;
      for (int j = 0; j < 8; j++) begin
         v[3'(7 - j)] = k[~SEL_TAB[s][j]];
      end
      return v;
   endfunction

   function automatic subkey_type subkeys(input logic [KEY_W-1:0] k);
      subkey_type sk;
      sk.k0 = gather(k, 0);
      sk.k1 = gather(k, 1);
      sk.k2 = gather(k, 2);
      sk.k3 = gather(k, 3);
      return sk;
   endfunction

endpackage

// File: hw/rtl/shadow32_block_encrypt.sv
// Top level of the pipelined Shadow-32 block encryptor.
//
//   channel  dir  handshake               payload
//   req      in   start & !busy           req_data  (sh32_pkg::req_type)
//   rsp      out  rsp_strobe, one cycle   rsp_data  (sh32_pkg::rsp_type)
//   csr      in   csr_valid & csr_ready   csr_data  (64-bit master key)
//
// One block enters per cycle while busy is low; each result passes the chain of
// ROUNDS round cells, each of which registers it, and leaves at its end.
// After reset and after each key write the key cell chain has to settle;
// busy is high while the settle counter is nonzero and during the write.
// The receiver cannot stall, so nothing holds the chain up.
module shadow32_block_encrypt #(
   parameter int ROUNDS = sh32_pkg::MAX_ROUNDS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  sh32_pkg::req_type          req_data,
   output logic                       rsp_strobe,
   output sh32_pkg::rsp_type          rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [sh32_pkg::KEY_W-1:0] csr_data
);
   import sh32_pkg::*;

   localparam int CNT_W = $clog2(ROUNDS + 1);

   logic [KEY_W-1:0] master_key_ff;
   logic [KEY_W-1:0] master_key_in;
   logic [CNT_W-1:0] settle_cnt_ff;
   logic [CNT_W-1:0] settle_cnt_in;
   logic             csr_beat;
   logic             req_beat;

   logic [KEY_W-1:0] key_chain [ROUNDS+1];
   subkey_type       sched     [ROUNDS];
   logic             vld_chain [ROUNDS+1];
   blk_type          blk_chain [ROUNDS+1];

   assign csr_ready = 1'b1;
   assign csr_beat  = csr_valid & csr_ready;
   assign busy      = (settle_cnt_ff != '0) | csr_valid;
   assign req_beat  = start & ~busy;

   always_comb begin
      master_key_in = master_key_ff;
      settle_cnt_in = settle_cnt_ff;
      if (csr_beat) begin
         master_key_in = csr_data;
         settle_cnt_in = CNT_W'(ROUNDS);
      end else if (settle_cnt_ff != '0) begin
         settle_cnt_in = settle_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         master_key_ff <= '0;
         settle_cnt_ff <= CNT_W'(ROUNDS);
      end else begin
         master_key_ff <= master_key_in;
         settle_cnt_ff <= settle_cnt_in;
      end
   end

   assign key_chain[0] = master_key_ff;
   assign vld_chain[0] = req_beat;
   assign blk_chain[0] = '{l0: req_data.left_a,  r0: req_data.right_a,
                           l1: req_data.left_b,  r1: req_data.right_b};

   for (genvar g = 0; g < ROUNDS; g++) begin : g_key
      sh32_key_cell u_key (
         .clock   (clock),
         .key_in  (key_chain[g]),
         .key_out (key_chain[g+1]),
         .sk_out  (sched[g])
      );
   end

   // round r takes the subkeys of schedule round ROUNDS-1-r
   for (genvar g = 0; g < ROUNDS; g++) begin : g_round
      sh32_round_cell u_round (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld_chain[g]),
         .in_blk    (blk_chain[g]),
         .keys      (sched[ROUNDS-1-g]),
         .out_valid (vld_chain[g+1]),
         .out_blk   (blk_chain[g+1])
      );
   end

   assign rsp_strobe              = vld_chain[ROUNDS];
   assign rsp_data.cipher_left_a  = blk_chain[ROUNDS].l0;
   assign rsp_data.cipher_right_a = blk_chain[ROUNDS].r0;
   assign rsp_data.cipher_left_b  = blk_chain[ROUNDS].l1;
   assign rsp_data.cipher_right_b = blk_chain[ROUNDS].r1;

endmodule

// File: hw/rtl/sh32_key_cell.sv
// One key schedule cell: advances the key state by one schedule round and hands it on.
module sh32_key_cell (
   input  logic                      clock,
   input  logic [sh32_pkg::KEY_W-1:0] key_in,
   output logic [sh32_pkg::KEY_W-1:0] key_out,
   output sh32_pkg::subkey_type      sk_out
);
   import sh32_pkg::*;

   logic [KEY_W-1:0] key_ff;

   always_ff @(posedge clock) begin
      key_ff <= key_step(key_in);
   end

   assign key_out = key_ff;
   assign sk_out  = subkeys(key_ff);

endmodule

// File: hw/rtl/sh32_round_cell.sv
// One encryption round cell: applies a round to the incoming block and registers it.
module sh32_round_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  sh32_pkg::blk_type    in_blk,
   input  sh32_pkg::subkey_type keys,
   output logic                 out_valid,
   output sh32_pkg::blk_type    out_blk
);
   import sh32_pkg::*;

   logic    valid_ff;
   blk_type blk_ff;
   blk_type blk_in;
   logic [7:0] nl0;
   logic [7:0] nl1;

   always_comb begin
      nl0       = f_round(in_blk.l0) ^ in_blk.r0 ^ keys.k2;
      nl1       = f_round(in_blk.l1) ^ in_blk.r1 ^ keys.k3;
      blk_in.r0 = f_round(nl0) ^ in_blk.l0 ^ keys.k0;
      blk_in.r1 = f_round(nl1) ^ in_blk.l1 ^ keys.k1;
      // left halves cross over at the end of the round
      blk_in.l0 = nl1;
      blk_in.l1 = nl0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
   end

   assign out_valid = valid_ff;
   assign out_blk   = blk_ff;

endmodule

// File: hw/rtl/sh32_checker.sv
// Port-level checks for the Shadow-32 encryptor and their binding to the top level.
module sh32_checker #(
   parameter int ROUNDS = sh32_pkg::MAX_ROUNDS
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe,
   input logic csr_valid,
   input logic csr_ready
);

   logic req_beat;

   assign req_beat = start & ~busy;

   // every accepted beat comes out once it has passed the ROUNDS round cell registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_beat |-> ##ROUNDS rsp_strobe)
      else $error("result missing after accepted beat");

   // no result without a matching beat taken at the head of the round cell chain
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_beat, ROUNDS))
      else $error("result without matching beat");

   // key chain must settle after a key write
   a_busy_after_key: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> busy)
      else $error("not busy after key write");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_strobe && busy))
      else $error("activity right after reset");

endmodule

bind shadow32_block_encrypt sh32_checker #(.ROUNDS(ROUNDS)) u_sh32_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);

// File: bench/shadow32_block_encrypt_tb.sv
// Self-checking bench for the Shadow-32 block encryptor, with its own cipher predictor.
module shadow32_block_encrypt_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sh32_pkg::*;

   localparam int NR = MAX_ROUNDS;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             start      = 1'b0;
   logic             busy;
   req_type          req_data   = '0;
   logic             rsp_strobe;
   rsp_type          rsp_data;
   logic             csr_valid  = 1'b0;
   logic             csr_ready;
   logic [KEY_W-1:0] csr_data   = '0;

   // subkey bytes per schedule round, k0..k3
   logic [7:0] round_keys [NR][4];
   rsp_type    cipher_q [$];
   rsp_type    want;
   int         errors = 0;

   shadow32_block_encrypt #(
      .ROUNDS(NR)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("shadow32_block_encrypt_tb: errors");
      $finish;
   end

   task automatic log_mismatch(input string what);
      $display("%0t ns: MISMATCH %s", $realtime, what);
      errors++;
   endtask

   // source position of each key position after the fixed shuffle
   function automatic int shuffle_src(input int p);
      if (p < 4) return p + 56;
      if (p < 16) return p + 12;
      if (p < 20) return p + 44;
      if (p < 48) return p + 8;
      return p - 48;
   endfunction

   function automatic void expand_key(input logic [63:0] mk);
      logic [0:63] kb;
      logic [0:63] nx;
      int          base;
      kb = mk;   // position 0 is the key MSB
      for (int r = 0; r < NR; r++) begin
         nx = kb;
         nx[56] = kb[56] & (kb[56] ^ kb[62]);
         nx[57] = kb[57] & (kb[57] ^ kb[63]);
         nx[58] = kb[58] & (kb[58] ^ kb[56] ^ kb[62]);
         nx[59] = kb[59] & (kb[59] ^ kb[57] ^ kb[63]);
         nx[60] = kb[60] & (kb[60] ^ kb[58] ^ kb[56] ^ kb[62]);
         nx[61] = kb[61] & (kb[61] ^ kb[59] ^ kb[57] ^ kb[63]);
         nx[62] = kb[62] & (kb[60] ^ kb[58] ^ kb[56]);
         nx[63] = kb[63] & (kb[61] ^ kb[59] ^ kb[57]);
         for (int p = 0; p < 64; p++) begin
            kb[p] = nx[shuffle_src(p)];
         end
         // each subkey byte: two nibbles eight positions apart, MSB first
         for (int s = 0; s < 4; s++) begin
            base = 4 * (s % 2) + 16 * (s / 2);
            for (int j = 0; j < 8; j++) begin
               round_keys[r][s] = {round_keys[r][s][6:0], kb[base + j + 4 * (j / 4)]};
            end
         end
      end
   endfunction

   function automatic logic [7:0] mix(input logic [7:0] x);
      logic [15:0] d;
      d = {x, x};
      return (d[14:7] & d[8:1]) ^ d[13:6];
   endfunction

   function automatic rsp_type encipher(input req_type p);
      logic [7:0] a0;
      logic [7:0] b0;
      logic [7:0] a1;
      logic [7:0] b1;
      logic [7:0] t;
      int         k;
      rsp_type    c;
      a0 = p.left_a;
      b0 = p.right_a;
      a1 = p.left_b;
      b1 = p.right_b;
      for (int r = 0; r < NR; r++) begin
         k  = NR - 1 - r;   // schedule runs backwards
         t  = mix(a0) ^ b0 ^ round_keys[k][2];
         b0 = a0;
         a0 = t;
         t  = mix(a1) ^ b1 ^ round_keys[k][3];
         b1 = a1;
         a1 = t;
         b0 = mix(a0) ^ b0 ^ round_keys[k][0];
         b1 = mix(a1) ^ b1 ^ round_keys[k][1];
         t  = a0;
         a0 = a1;
         a1 = t;
      end
      c.cipher_left_a  = a0;
      c.cipher_right_a = b0;
      c.cipher_left_b  = a1;
      c.cipher_right_b = b1;
      return c;
   endfunction

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] exp);
      if (got !== exp) begin
         log_mismatch($sformatf("%s got %02h want %02h", name, got, exp));
      end
   endtask

   // result beats cannot be held off: each is taken at the edge it is seen
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (cipher_q.size() == 0) begin
            log_mismatch("result beat with nothing outstanding");
         end else begin
            want = cipher_q.pop_front();
            check_field("cipher_left_a", rsp_data.cipher_left_a, want.cipher_left_a);
            check_field("cipher_right_a", rsp_data.cipher_right_a, want.cipher_right_a);
            check_field("cipher_left_b", rsp_data.cipher_left_b, want.cipher_left_b);
            check_field("cipher_right_b", rsp_data.cipher_right_b, want.cipher_right_b);
         end
      end
   end

   // leaves start high; the caller lowers it when it idles
   task automatic send_block(input req_type blk);
      start    <= 1'b1;
      req_data <= blk;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      cipher_q.push_back(encipher(blk));
   endtask

   task automatic sender_gap(input int pct);
      while ($urandom_range(99) < pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain_pipe;
      start <= 1'b0;
      while (cipher_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_key(input logic [63:0] key);
      drain_pipe();
      csr_valid <= 1'b1;
      csr_data  <= key;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      csr_valid <= 1'b0;
      expand_key(key);
   endtask

   function automatic logic [63:0] pick_key;
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic req_type random_block;
      logic [31:0] v;
      v = $urandom;
      for (int b = 0; b < 4; b++) begin
         if ($urandom_range(7) == 0) begin
            v[8 * b +: 8] = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
         end
      end
      return v;
   endfunction

   task automatic test_reset_key;
      send_block(32'h0000_0000);
      send_block(32'hFFFF_FFFF);
      send_block(32'h8001_7FFE);
   endtask

   task automatic test_directed_keys;
      logic [63:0] keys [6];
      keys = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
               64'h0000_0000_0000_00FF, 64'h0123_4567_89AB_CDEF, 64'h0000_0000_0000_0000};
      foreach (keys[i]) begin
         write_key(keys[i]);
         send_block(32'h0000_0000);
         send_block(32'hFFFF_FFFF);
         send_block(32'h8001_7FFE);
      end
   endtask

   // back-to-back burst, a full pause until the pipe is empty, then another burst
   task automatic test_burst_and_drain;
      write_key(pick_key());
      repeat (40) send_block(random_block());
      drain_pipe();
      repeat (40) send_block(random_block());
   endtask

   task automatic test_random(input int count, input int idle_pct);
      for (int n = 0; n < count; n++) begin
         if (n % 110 == 0) begin
            write_key(pick_key());
         end else if ($urandom_range(199) == 0) begin
            drain_pipe();
         end
         sender_gap(idle_pct);
         send_block(random_block());
      end
   endtask

   initial begin
      expand_key('0);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_key();
      test_directed_keys();
      test_burst_and_drain();
      test_random(640, 35);
      test_random(640, 74);
      test_random(640, 0);
      drain_pipe();
      repeat (NR + 4) @(posedge clock);
      if (cipher_q.size() != 0) begin
         log_mismatch($sformatf("%0d results never arrived", cipher_q.size()));
      end
      if (errors == 0) begin
         $display("shadow32_block_encrypt_tb: clean");
      end else begin
         $display("shadow32_block_encrypt_tb: errors");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/sh32_pkg.sv
hw/rtl/sh32_key_cell.sv
hw/rtl/sh32_round_cell.sv
hw/rtl/shadow32_block_encrypt.sv
hw/rtl/sh32_checker.sv
bench/shadow32_block_encrypt_tb.sv
